/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define FRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, reset masks the check.
`define FRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/fre_pkg.sv */
// ----------------------------------------------------------------------------
// fre_pkg
// Widths, defaults and shared types of the frame RMS energy block.
// ----------------------------------------------------------------------------
package fre_pkg;

   localparam int SAMPLE_W              = 16;
   localparam int SQ_W                  = 31;  // square of a 16-bit sample, at most 2^30
   localparam int MEAN_W                = 39;  // 256 * mean square, at most 2^38
   localparam int RAD_W                 = 40;  // radicand, even width
   localparam int ROOT_W                = 20;
   localparam int SREM_W                = ROOT_W + 1;
   localparam int RMS_W                 = 20;
   localparam int DEFAULT_MAX_FRAME_LEN = 1024;

   // Accumulator commands from the sequencer.
   typedef struct packed {
      logic capture;  // latch the incoming sample
      logic add;      // add the square, or saturate
      logic clear;    // start a new frame
   } acc_ctl_type;

endpackage

/* src/frame_rms_energy.sv */
// ----------------------------------------------------------------------------
// frame_rms_energy
// RMS energy of sample frames: sum of squares, divide by count, square root.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Payload
// req       in   req_valid/req_stall   req_sample, req_frame_end
// rsp       out  rsp_valid/rsp_stall   rsp_rms_value, rsp_overflow
//
// A sample without frame end is latched, squared and accumulated.
// A frame-end beat then divides by the count and takes the square root:
// the shared trial subtractor runs one quotient bit, then one root bit, a cycle.
// The result register lets new samples in while a result waits on rsp_stall;
// the next frame end holds in its final state until that register is free.
// Reset is synchronous and clears the accumulator and the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_rms_energy import fre_pkg::*; #(
   parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_frame_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [RMS_W-1:0]           rsp_rms_value,
   output logic                       rsp_overflow
);

   localparam int CNT_W    = $clog2(MAX_FRAME_LEN + 1);
   localparam int SUM_W    = 31 + $clog2(MAX_FRAME_LEN);
   localparam int NUM_W    = SUM_W + 8;
   localparam int DIV_OP_W = CNT_W + 1;
   localparam int SQ_OP_W  = ROOT_W + 3;
   localparam int SUB_W    = (DIV_OP_W > SQ_OP_W) ? DIV_OP_W : SQ_OP_W;
   localparam int ITER_W   = $clog2(NUM_W);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SQUARE    = 3'd1;
   localparam logic [2:0] ST_ACCUM     = 3'd2;
   localparam logic [2:0] ST_DIV_INIT  = 3'd3;
   localparam logic [2:0] ST_DIV       = 3'd4;
   localparam logic [2:0] ST_SQRT_INIT = 3'd5;
   localparam logic [2:0] ST_SQRT      = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic              end_ff, end_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]  rms_ff, rms_in;
   logic              ovf_ff, ovf_in;

   acc_ctl_type       acc_ctl;
   logic [SUM_W-1:0]  acc_sum;
   logic [CNT_W-1:0]  acc_count;
   logic              acc_exceeded;

   logic              mode_sqrt;
   logic [SUB_W-1:0]  trial_minuend;
   logic [SUB_W-1:0]  trial_diff;
   logic              trial_fits;
   logic              req_accept;
   logic              rsp_free;

   fre_accum #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .CNT_W         (CNT_W),
      .SUM_W         (SUM_W)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .ctl             (acc_ctl),
      .sample          (req_sample),
      .square_sum      (acc_sum),
      .sample_count    (acc_count),
      .length_exceeded (acc_exceeded)
   );

   fre_trial_unit #(
      .CNT_W (CNT_W),
      .SUB_W (SUB_W)
   ) u_trial (
      .mode_sqrt (mode_sqrt),
      .div_rem   (rem_ff),
      .div_bit   (num_ff[NUM_W-1]),
      .divisor   (acc_count),
      .sq_rem    (srem_ff),
      .sq_bits   (rad_ff[RAD_W-1:RAD_W-2]),
      .root      (root_ff),
      .minuend   (trial_minuend),
      .diff      (trial_diff),
      .fits      (trial_fits)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign mode_sqrt  = (state_ff == ST_SQRT);

   always_comb begin
      state_in     = state_ff;
      end_in       = end_ff;
      iter_in      = iter_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      rms_in       = rms_ff;
      ovf_in       = ovf_ff;
      acc_ctl      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_ctl.capture = 1'b1;
               end_in          = req_frame_end;
               state_in        = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_ctl.add = 1'b1;
            state_in    = end_ff ? ST_DIV_INIT : ST_IDLE;
         end
         ST_DIV_INIT: begin
            num_in   = {acc_sum, 8'd0};
            rem_in   = '0;
            iter_in  = ITER_W'(NUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // shift in one quotient bit
            rem_in = trial_fits ? trial_diff[CNT_W-1:0] : trial_minuend[CNT_W-1:0];
            num_in = {num_ff[NUM_W-2:0], trial_fits};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_SQRT_INIT;
            end
         end
         ST_SQRT_INIT: begin
            rad_in   = RAD_W'(num_ff[MEAN_W-1:0]);
            srem_in  = '0;
            root_in  = '0;
            iter_in  = ITER_W'(ROOT_W - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // two radicand bits in, one root bit out
            srem_in = trial_fits ? trial_diff[SREM_W-1:0] : trial_minuend[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], trial_fits};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rms_in        = RMS_W'(root_ff);
               ovf_in        = acc_exceeded;
               acc_ctl.clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff  <= end_in;
      iter_ff <= iter_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      rms_ff  <= rms_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rms_value = rms_ff;
   assign rsp_overflow  = ovf_ff;

   `FRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall)
   `FRE_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, acc_count <= CNT_W'(MAX_FRAME_LEN))
   `FRE_ASSERT_SAME(a_divisor_nonzero, clock, reset, state_ff == ST_DIV, acc_count != '0)
   `FRE_ASSERT_SAME(a_rms_bound, clock, reset, rsp_valid_ff, rms_ff <= RMS_W'(524288))

endmodule

/* src/fre_accum.sv */
// ----------------------------------------------------------------------------
// fre_accum
// Squares samples and accumulates sum of squares and count, saturating.
// ----------------------------------------------------------------------------
module fre_accum import fre_pkg::*; #(
   parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN,
   parameter int CNT_W         = $clog2(MAX_FRAME_LEN + 1),
   parameter int SUM_W         = 31 + $clog2(MAX_FRAME_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  acc_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]           square_sum,
   output logic [CNT_W-1:0]           sample_count,
   output logic                       length_exceeded
);

   logic signed [SAMPLE_W-1:0]   sample_ff;
   logic signed [2*SAMPLE_W-1:0] product;
   logic [SQ_W-1:0]              sq_ff;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         exceeded_ff, exceeded_in;
   logic                         full;

   assign product = sample_ff * sample_ff;
   assign full    = (count_ff == CNT_W'(MAX_FRAME_LEN));

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         sample_ff <= sample;
      end
      sq_ff <= product[SQ_W-1:0];
   end

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      exceeded_in = exceeded_ff;
      if (ctl.clear) begin
         sum_in      = '0;
         count_in    = '0;
         exceeded_in = 1'b0;
      end else if (ctl.add) begin
         if (full) begin
            // hold sum and count, flag the frame
            exceeded_in = 1'b1;
         end else begin
            sum_in   = sum_ff + SUM_W'(sq_ff);
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         exceeded_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         exceeded_ff <= exceeded_in;
      end
   end

   assign square_sum      = sum_ff;
   assign sample_count    = count_ff;
   assign length_exceeded = exceeded_ff;

endmodule

/* src/fre_trial_unit.sv */
// ----------------------------------------------------------------------------
// fre_trial_unit
// Shared trial subtractor for restoring divide and digit-by-digit root.
// ----------------------------------------------------------------------------
module fre_trial_unit import fre_pkg::*; #(
   parameter int CNT_W = 11,
   parameter int SUB_W = 23
) (
   input  logic               mode_sqrt,
   input  logic [CNT_W-1:0]   div_rem,
   input  logic               div_bit,
   input  logic [CNT_W-1:0]   divisor,
   input  logic [SREM_W-1:0]  sq_rem,
   input  logic [1:0]         sq_bits,
   input  logic [ROOT_W-1:0]  root,
   output logic [SUB_W-1:0]   minuend,
   output logic [SUB_W-1:0]   diff,
   output logic               fits
);

   logic [SUB_W-1:0] subtrahend;
   logic             borrow;

   always_comb begin
      if (mode_sqrt) begin
         minuend    = SUB_W'({sq_rem, sq_bits});
         subtrahend = SUB_W'({root, 2'b01});
      end else begin
         minuend    = SUB_W'({div_rem, div_bit});
         subtrahend = SUB_W'(divisor);
      end
   end

   assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};
   assign fits           = !borrow;

endmodule

/* verif/tb_frame_rms_energy.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_rms_energy
// Self-checking bench for the frame RMS energy block. Samples are sent in
// frames of random length. An in-bench model keeps the sum of squares, the
// count and the overrun flag, and queues the expected RMS and overflow bit
// for each frame end. The result monitor checks each result beat against
// the oldest queued frame. The sender and the receiver idle at random, the
// receiver holds off for a long stretch once, and a frame past the maximum
// length exercises the saturating accumulator.
// ----------------------------------------------------------------------------
module tb_frame_rms_energy;
   import fre_pkg::*;

   localparam int FRAME_LEN_MAX = DEFAULT_MAX_FRAME_LEN;
   localparam int HOLD_CYCLES   = 1000;
   localparam int STALL_LIMIT   = 20000;
   localparam int TAIL_CYCLES   = 200;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct packed {
      logic [RMS_W-1:0] rms;
      logic             overflow;
   } frame_rms_type;

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample    = '0;
   logic                       req_frame_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic [RMS_W-1:0]           rsp_rms_value;
   logic                       rsp_overflow;

   // frame energy model
   logic [40:0]    energy_sum   = '0;
   logic [10:0]    energy_count = '0;
   logic           energy_clipped = 1'b0;
   frame_rms_type  frame_rms_q[$];

   int src_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int samples_sent  = 0;
   int frames_closed = 0;
   int frames_clipped = 0;
   int results_checked = 0;
   int mismatches    = 0;

   frame_rms_energy #(.MAX_FRAME_LEN(FRAME_LEN_MAX)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rms_value (rsp_rms_value),
      .rsp_overflow  (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Floor square root, one root bit at a time from the top.
   function automatic logic [RMS_W-1:0] floor_root(input logic [63:0] radicand);
      logic [RMS_W-1:0] root;
      logic [RMS_W-1:0] trial;
      logic [63:0]      probe;
      root = '0;
      for (int b = RMS_W - 1; b >= 0; b--) begin
         trial    = root;
         trial[b] = 1'b1;
         probe    = 64'(trial);
         if (probe * probe <= radicand) root = trial;
      end
      return root;
   endfunction

   task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] smp,
                                    input logic frame_end);
      logic [SAMPLE_W-1:0] mag;
      logic [63:0]         mean_sq;
      frame_rms_type       res;
      mag = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
      // saturate: a sample past the maximum length is dropped
      if (energy_count >= FRAME_LEN_MAX) begin
         energy_clipped = 1'b1;
      end else begin
         energy_sum   = energy_sum + 41'(mag) * 41'(mag);
         energy_count = energy_count + 1'b1;
      end
      if (frame_end) begin
         if (energy_count == 0) mean_sq = '0;
         else mean_sq = ({23'd0, energy_sum} << 8) / 64'(energy_count);
         res.rms      = floor_root(mean_sq);
         res.overflow = energy_clipped;
         frame_rms_q.push_back(res);
         frames_closed++;
         if (energy_clipped) frames_clipped++;
         energy_sum     = '0;
         energy_count   = '0;
         energy_clipped = 1'b0;
      end
   endtask

   // Send one sample beat; valid stays high after acceptance unless the next
   // call idles or the caller lowers it.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                              input logic frame_end);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid     <= 1'b1;
      req_sample    <= smp;
      req_frame_end <= frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      accumulate_sample(smp, frame_end);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (frame_rms_q.size() != 0);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2, 3:    return SAMPLE_W'(int'($urandom_range(64)) - 32);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      // single-sample frames, the extremes among them
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b1);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      // opposite extremes in one frame
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      // alternating bit patterns
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b1);
      // mean that is not a whole square: root rounds down
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b0);
      send_sample(-16'sd2, 1'b1);
      // largest RMS over several samples
      repeat (3) send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
   endtask

   task automatic test_random_frames(input int budget);
      int sent;
      int flen;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(19))
            0:       flen = $urandom_range(200, 41);
            1, 2, 3: flen = $urandom_range(40, 9);
            default: flen = $urandom_range(8, 1);
         endcase
         for (int i = 1; i <= flen; i++) send_sample(pick_sample(), i == flen);
         sent += flen;
      end
   endtask

   // Frame past the maximum length: full-scale samples fill the accumulator
   // to its top, the samples after them are dropped, the frame end among them.
   task automatic test_long_frames();
      for (int i = 1; i <= FRAME_LEN_MAX + 2; i++)
         send_sample(i > FRAME_LEN_MAX ? SAMPLE_MAX : SAMPLE_MIN,
                     i == FRAME_LEN_MAX + 2);
   endtask

   // Receiver holds off while short frames keep coming, so the block fills
   // and stalls its input.
   task automatic test_receiver_hold();
      int flen;
      hold_requests++;
      repeat (30) begin
         flen = $urandom_range(3, 1);
         for (int i = 1; i <= flen; i++) send_sample(pick_sample(), i == flen);
      end
   endtask

   // result monitor and receiver stall
   always @(posedge clock) begin
      frame_rms_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_rms_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual rms_value %0d overflow %0b",
                        $time, rsp_rms_value, rsp_overflow);
               mismatches++;
            end else begin
               want = frame_rms_q.pop_front();
               results_checked++;
               if (rsp_rms_value !== want.rms) begin
                  $display("%0t: rms_value mismatch, expected %0d, actual %0d",
                           $time, want.rms, rsp_rms_value);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch, expected %0b, actual %0b",
                           $time, want.overflow, rsp_overflow);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (holds_served != hold_requests) begin
            rsp_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_idle_pct = 36;
      rsp_idle_pct = 82;
      test_directed();
      test_random_frames(250);
      wait_drained();

      src_idle_pct = 82;
      rsp_idle_pct = 36;
      test_receiver_hold();
      test_random_frames(250);
      wait_drained();

      src_idle_pct = 0;
      rsp_idle_pct = 0;
      test_long_frames();
      test_random_frames(250);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (frame_rms_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, frame_rms_q.size());
         mismatches++;
      end
      $display("Sent %0d samples in %0d frames, %0d of them past the length limit.",
               samples_sent, frames_closed, frames_clipped);
      $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* frame_rms_energy.f */
+incdir+src
src/fre_pkg.sv
src/fre_accum.sv
src/fre_trial_unit.sv
src/frame_rms_energy.sv
verif/tb_frame_rms_energy.sv
